// ----- sv/tpc_pkg.sv -----
// shared types and constants for the touch point calibrator
package tpc_pkg;

  // field widths
  localparam int RAW_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int PT_W       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // arithmetic widths, sized for screens up to 4096
  localparam int M_W      = 13;
  localparam int N_W      = 17;
  localparam int SPAN_W   = 17;
  localparam int PROD_W   = 30;
  localparam int REM_W    = 17;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS  = PROD_W / BITS_PER_STEP;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // default screen geometry
  localparam int DEF_SCREEN_W = 480;
  localparam int DEF_SCREEN_H = 480;

  // touch count limit
  localparam logic [NIB_W-1:0] MAX_TOUCHES = NIB_W'(5);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_PRESENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_MIN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_MAX    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_MIN    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_MAX    = CFG_IDX_W'(5);

  // calibration reset values
  localparam logic signed [CFG_DATA_W-1:0] CAL_MIN_RESET = CFG_DATA_W'(0);
  localparam logic signed [CFG_DATA_W-1:0] CAL_MAX_RESET = CFG_DATA_W'(479);

  // axis select
  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_t;

  // controller to datapath commands
  typedef struct packed {
    logic  load_in;
    logic  prep;
    logic  setup;
    logic  div_step;
    logic  store;
    logic  load_out;
    axis_t axis;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic touch_ok;
  } status_t;

endpackage

// ----- sv/touch_point_calibrator_unit.sv -----
// top level of the touch point calibrator
// Each accepted poll yields exactly one result. A released poll (controller
// absent, touch count outside 1 to 5, or incomplete data) skips the arithmetic
// and returns the held point with pressed low. A valid touch works each axis,
// X then Y, through the mirror and scale multiply, the divider setup, the
// shared signed divider, which resolves two quotient bits a cycle, and a final
// clamp and store.
// The poll side is stalled while a poll is being worked; a finished result
// waits in its own register, so the next poll can be taken meanwhile.
// Configuration writes are always ready and should be made while idle.
module touch_point_calibrator_unit #(
  parameter int SCREEN_W = tpc_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = tpc_pkg::DEF_SCREEN_H
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            poll_valid,
  output logic                            poll_stall,
  input  logic [tpc_pkg::NIB_W-1:0]       touch_count,
  input  logic [tpc_pkg::BYTE_W-1:0]      x_high,
  input  logic [tpc_pkg::BYTE_W-1:0]      x_low,
  input  logic [tpc_pkg::BYTE_W-1:0]      y_high,
  input  logic [tpc_pkg::BYTE_W-1:0]      y_low,
  input  logic                            data_complete,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            pressed,
  output logic [tpc_pkg::PT_W-1:0]        point_x,
  output logic [tpc_pkg::PT_W-1:0]        point_y
);

  tpc_pkg::cmd_t    cmd;
  tpc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  tpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath
  tpc_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .touch_count   (touch_count),
    .x_high        (x_high),
    .x_low         (x_low),
    .y_high        (y_high),
    .y_low         (y_low),
    .data_complete (data_complete),
    .cmd           (cmd),
    .status        (status),
    .pressed       (pressed),
    .point_x       (point_x),
    .point_y       (point_y)
  );

endmodule

// ----- sv/tpc_ctrl.sv -----
// sequencing state machine for the touch point calibrator
module tpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_valid,
  output logic              poll_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  tpc_pkg::status_t  status,
  output tpc_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_SETUP  = 6'b000100,
    S_DIV    = 6'b001000,
    S_STORE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  tpc_pkg::axis_t                  axis;
  tpc_pkg::axis_t                  axis_next;
  logic [tpc_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic [tpc_pkg::STEP_CNT_W-1:0]  step_cnt_next;
  logic                            out_free;

  assign poll_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // next state and commands
  always_comb begin
    state_next    = state;
    axis_next     = axis;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.axis      = axis;
    case (state)
      S_IDLE: begin
        if (poll_valid) begin
          cmd.load_in = 1'b1;
          axis_next   = tpc_pkg::AXIS_X;
          state_next  = status.touch_ok ? S_PREP : S_FINISH;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup     = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == tpc_pkg::STEP_CNT_W'(tpc_pkg::DIV_STEPS - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (axis == tpc_pkg::AXIS_X) begin
          axis_next  = tpc_pkg::AXIS_Y;
          state_next = S_PREP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= tpc_pkg::AXIS_X;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      axis     <= axis_next;
      step_cnt <= step_cnt_next;
    end
  end

  // result request valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ----- sv/tpc_dp.sv -----
// calibration datapath: registers, mapping multiply, shared divider, clamp
module tpc_dp #(
  parameter int SCREEN_W = tpc_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = tpc_pkg::DEF_SCREEN_H
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tpc_pkg::NIB_W-1:0]         touch_count,
  input  logic [tpc_pkg::BYTE_W-1:0]        x_high,
  input  logic [tpc_pkg::BYTE_W-1:0]        x_low,
  input  logic [tpc_pkg::BYTE_W-1:0]        y_high,
  input  logic [tpc_pkg::BYTE_W-1:0]        y_low,
  input  logic                              data_complete,
  input  tpc_pkg::cmd_t                     cmd,
  output tpc_pkg::status_t                  status,
  output logic                              pressed,
  output logic [tpc_pkg::PT_W-1:0]          point_x,
  output logic [tpc_pkg::PT_W-1:0]          point_y
);

  localparam int RAW_W  = tpc_pkg::RAW_W;
  localparam int M_W    = tpc_pkg::M_W;
  localparam int N_W    = tpc_pkg::N_W;
  localparam int SPAN_W = tpc_pkg::SPAN_W;
  localparam int PROD_W = tpc_pkg::PROD_W;
  localparam int REM_W  = tpc_pkg::REM_W;
  localparam int PT_W   = tpc_pkg::PT_W;
  localparam int DW     = tpc_pkg::CFG_DATA_W;

  localparam logic signed [M_W-1:0] S1_X   = M_W'(SCREEN_W - 1);
  localparam logic signed [M_W-1:0] S1_Y   = M_W'(SCREEN_H - 1);
  localparam logic [PROD_W-1:0]     SIZE_X = PROD_W'(SCREEN_W);
  localparam logic [PROD_W-1:0]     SIZE_Y = PROD_W'(SCREEN_H);

  // configuration
  logic                  controller_present;
  logic                  cal_enable;
  logic signed [DW-1:0]  cal_x_min;
  logic signed [DW-1:0]  cal_x_max;
  logic signed [DW-1:0]  cal_y_min;
  logic signed [DW-1:0]  cal_y_max;

  // poll capture
  logic [RAW_W-1:0]      raw_x;
  logic [RAW_W-1:0]      raw_y;
  logic                  touch_q;

  // mapping stage
  logic signed [M_W-1:0]    m_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [SPAN_W-1:0] span_r;
  logic                     bypass;

  // divider
  logic [PROD_W-1:0]     quo;
  logic [PROD_W-1:0]     quo_next;
  logic [REM_W-1:0]      rem;
  logic [REM_W-1:0]      rem_next;
  logic [REM_W-1:0]      divisor;
  logic                  neg;

  // held point and output
  logic [PT_W-1:0]       held_x;
  logic [PT_W-1:0]       held_y;

  // per-axis selection
  logic [RAW_W-1:0]         raw_sel;
  logic signed [DW-1:0]     lo_sel;
  logic signed [DW-1:0]     hi_sel;
  logic signed [M_W-1:0]    s1_sel;
  logic [PROD_W-1:0]        size_sel;
  logic signed [M_W-1:0]    m_val;
  logic signed [N_W-1:0]    n_val;
  logic signed [SPAN_W-1:0] span_val;
  logic signed [PROD_W-1:0] prod_val;
  logic                     clamp_low;
  logic [PROD_W-1:0]        mag;
  logic [PT_W-1:0]          axis_result;

  // touch qualification on the live poll
  assign status.touch_ok = controller_present && data_complete &&
                           (touch_count != '0) && (touch_count <= tpc_pkg::MAX_TOUCHES);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      controller_present <= 1'b0;
      cal_enable         <= 1'b0;
      cal_x_min          <= tpc_pkg::CAL_MIN_RESET;
      cal_x_max          <= tpc_pkg::CAL_MAX_RESET;
      cal_y_min          <= tpc_pkg::CAL_MIN_RESET;
      cal_y_max          <= tpc_pkg::CAL_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpc_pkg::CFG_CTRL_PRESENT: controller_present <= cfg_data[0];
        tpc_pkg::CFG_CAL_ENABLE:   cal_enable         <= cfg_data[0];
        tpc_pkg::CFG_CAL_X_MIN:    cal_x_min          <= cfg_data;
        tpc_pkg::CFG_CAL_X_MAX:    cal_x_max          <= cfg_data;
        tpc_pkg::CFG_CAL_Y_MIN:    cal_y_min          <= cfg_data;
        tpc_pkg::CFG_CAL_Y_MAX:    cal_y_max          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // capture the poll request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_x   <= {x_high[RAW_W-tpc_pkg::BYTE_W-1:0], x_low};
      raw_y   <= {y_high[RAW_W-tpc_pkg::BYTE_W-1:0], y_low};
      touch_q <= status.touch_ok;
    end
  end

  // axis operand selection
  always_comb begin
    if (cmd.axis == tpc_pkg::AXIS_Y) begin
      raw_sel  = raw_y;
      lo_sel   = cal_y_min;
      hi_sel   = cal_y_max;
      s1_sel   = S1_Y;
      size_sel = SIZE_Y;
    end else begin
      raw_sel  = raw_x;
      lo_sel   = cal_x_min;
      hi_sel   = cal_x_max;
      s1_sel   = S1_X;
      size_sel = SIZE_X;
    end
  end

  // mirror, offset, span and scale multiply
  assign m_val    = s1_sel - $signed({1'b0, raw_sel});
  assign n_val    = N_W'(m_val) - N_W'(lo_sel);
  assign span_val = SPAN_W'(hi_sel) - SPAN_W'(lo_sel);
  assign prod_val = PROD_W'(n_val) * PROD_W'(s1_sel);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      m_r    <= m_val;
      prod   <= prod_val;
      span_r <= span_val;
      bypass <= !cal_enable || (span_val == '0);
    end
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [REM_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < tpc_pkg::BITS_PER_STEP; i++) begin
      trial    = {rem_next, quo_next[PROD_W-1]};
      quo_next = {quo_next[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      neg     <= prod[PROD_W-1] ^ span_r[SPAN_W-1];
      quo     <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      divisor <= span_r[SPAN_W-1] ? REM_W'(-span_r) : REM_W'(span_r);
      rem     <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // clamp to the screen
  always_comb begin
    if (bypass) begin
      clamp_low = m_r[M_W-1];
      mag       = PROD_W'($unsigned(m_r));
    end else begin
      clamp_low = neg && (quo != '0);
      mag       = quo;
    end
    if (clamp_low) begin
      axis_result = '0;
    end else if (mag >= size_sel) begin
      axis_result = PT_W'(size_sel - 1'b1);
    end else begin
      axis_result = mag[PT_W-1:0];
    end
  end

  // held point
  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else if (cmd.store) begin
      if (cmd.axis == tpc_pkg::AXIS_Y) begin
        held_y <= axis_result;
      end else begin
        held_x <= axis_result;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pressed <= touch_q;
      point_x <= held_x;
      point_y <= held_y;
    end
  end

endmodule

// ----- tb/touch_point_calibrator_unit_test.sv -----
// testbench for the touch point calibrator: directed and random polls checked by a scoreboard
module touch_point_calibrator_unit_test;
  import tpc_pkg::*;

  localparam int SCREEN_W   = DEF_SCREEN_W;
  localparam int SCREEN_H   = DEF_SCREEN_H;
  localparam int IDLE_LIMIT = 2000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

  typedef struct packed {
    logic            pressed;
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
  } touch_result_t;

  // mirrors calibration settings and the held point, queues expected points
  class point_tracker;
    bit                           present;
    bit                           cal_on;
    logic signed [CFG_DATA_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [PT_W-1:0]              held_x, held_y;
    touch_result_t                expected_points[$];
    int                           mismatches;

    function new();
      present    = 1'b0;
      cal_on     = 1'b0;
      x_lo       = CAL_MIN_RESET;
      x_hi       = CAL_MAX_RESET;
      y_lo       = CAL_MIN_RESET;
      y_hi       = CAL_MAX_RESET;
      held_x     = '0;
      held_y     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CTRL_PRESENT: present = data[0];
        CFG_CAL_ENABLE:   cal_on  = data[0];
        CFG_CAL_X_MIN:    x_lo    = data;
        CFG_CAL_X_MAX:    x_hi    = data;
        CFG_CAL_Y_MIN:    y_lo    = data;
        CFG_CAL_Y_MAX:    y_hi    = data;
        default: ;
      endcase
    endfunction

    // mirror, optional two-point scaling, clamp to the screen
    function logic [PT_W-1:0] scale_axis(input logic [RAW_W-1:0] raw, input int size,
                                         input logic signed [CFG_DATA_W-1:0] lo,
                                         input logic signed [CFG_DATA_W-1:0] hi);
      longint m;
      longint span;
      m = longint'(size - 1) - longint'(raw);
      if (cal_on) begin
        span = longint'(hi) - longint'(lo);
        if (span != 0) m = ((m - longint'(lo)) * longint'(size - 1)) / span;
      end
      if (m < 0) m = 0;
      if (m >= size) m = size - 1;
      return m[PT_W-1:0];
    endfunction

    function void note_poll(input logic [NIB_W-1:0] cnt, input logic [15:0] xw,
                            input logic [15:0] yw, input logic done);
      touch_result_t r;
      bit            touch_ok;
      touch_ok = present && (cnt >= 1) && (cnt <= MAX_TOUCHES) && done;
      if (touch_ok) begin
        held_x = scale_axis(xw[RAW_W-1:0], SCREEN_W, x_lo, x_hi);
        held_y = scale_axis(yw[RAW_W-1:0], SCREEN_H, y_lo, y_hi);
      end
      r.pressed = touch_ok;
      r.x       = held_x;
      r.y       = held_y;
      expected_points.push_back(r);
    endfunction

    function void check_result(input touch_result_t got);
      touch_result_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point: pressed=%0b x=%0d y=%0d", got.pressed, got.x, got.y);
        return;
      end
      want = expected_points.pop_front();
      if (got.pressed !== want.pressed || got.x !== want.x || got.y !== want.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point mismatch: expected pressed=%0b x=%0d y=%0d, got pressed=%0b x=%0d y=%0d",
                   want.pressed, want.x, want.y, got.pressed, got.x, got.y);
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  poll_valid    = 1'b0;
  logic                  poll_stall;
  logic [NIB_W-1:0]      touch_count   = '0;
  logic [BYTE_W-1:0]     x_high        = '0;
  logic [BYTE_W-1:0]     x_low         = '0;
  logic [BYTE_W-1:0]     y_high        = '0;
  logic [BYTE_W-1:0]     y_low         = '0;
  logic                  data_complete = 1'b0;
  logic                  result_valid;
  logic                  result_stall  = 1'b0;
  logic                  pressed;
  logic [PT_W-1:0]       point_x;
  logic [PT_W-1:0]       point_y;

  bit           quiet = 1'b0;
  int           idle_cycles = 0;
  point_tracker tracker = new();

  touch_point_calibrator_unit #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .touch_count  (touch_count),
    .x_high       (x_high),
    .x_low        (x_low),
    .y_high       (y_high),
    .y_low        (y_low),
    .data_complete(data_complete),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pressed      (pressed),
    .point_x      (point_x),
    .point_y      (point_y)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // track accepted requests and results, count cycles with no progress
  always @(posedge clk) begin
    if (!rst && poll_valid && !poll_stall)
      tracker.note_poll(touch_count, {x_high, x_low}, {y_high, y_low}, data_complete);
    if (!rst && result_valid && !result_stall)
      tracker.check_result(touch_result_t'{pressed, point_x, point_y});
    if (rst || (poll_valid && !poll_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("touch_point_calibrator_unit_test NOT OK");
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (!quiet && !rst && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  // one register write request
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one poll request, wait until taken, then maybe go quiet for a while
  task automatic issue_poll(input logic [NIB_W-1:0] cnt, input logic [15:0] xw,
                            input logic [15:0] yw, input logic done);
    poll_valid    <= 1'b1;
    touch_count   <= cnt;
    {x_high, x_low} <= xw;
    {y_high, y_low} <= yw;
    data_complete <= done;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      poll_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // mostly well-formed touches, some noise polls
  task automatic issue_random_poll();
    logic [NIB_W-1:0] cnt;
    logic [15:0]      xw;
    logic [15:0]      yw;
    logic             done;
    xw = 16'($urandom);
    yw = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      cnt  = NIB_W'($urandom_range(1, MAX_TOUCHES));
      done = 1'b1;
    end else begin
      cnt  = NIB_W'($urandom);
      done = 1'($urandom);
    end
    // on-screen readings most of the time, upper nibble of the high byte stays random
    if ($urandom_range(0, 2) != 0) begin
      xw[RAW_W-1:0] = RAW_W'($urandom_range(0, SCREEN_W - 1));
      yw[RAW_W-1:0] = RAW_W'($urandom_range(0, SCREEN_H - 1));
    end
    issue_poll(cnt, xw, yw, done);
  endtask

  // stop sending and let every outstanding point come back
  task automatic drain_results();
    poll_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // new calibration setting for a random phase
  task automatic configure_phase(input int mode);
    logic signed [CFG_DATA_W-1:0] xl, xh, yl, yh;
    case (mode)
      0: begin
        xl = CFG_DATA_W'($urandom_range(0, 60));
        xh = CFG_DATA_W'($urandom_range(420, 479));
        yl = CFG_DATA_W'($urandom_range(0, 60));
        yh = CFG_DATA_W'($urandom_range(420, 479));
      end
      1: begin
        xl = CFG_DATA_W'($urandom_range(420, 479));
        xh = CFG_DATA_W'($urandom_range(0, 60));
        yl = CFG_DATA_W'($urandom_range(420, 479));
        yh = CFG_DATA_W'($urandom_range(0, 60));
      end
      2: begin
        xl = CFG_DATA_W'($urandom);
        xh = CFG_DATA_W'($urandom);
        yl = CFG_DATA_W'($urandom);
        yh = CFG_DATA_W'($urandom);
      end
      3: begin
        xl = CFG_DATA_W'($urandom_range(0, 479));
        xh = xl;
        yl = CFG_DATA_W'($urandom);
        yh = ($urandom_range(0, 1) != 0) ? yl : CFG_DATA_W'($urandom);
      end
      default: begin
        xl = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
        xh = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
        yl = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
        yh = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      end
    endcase
    write_reg(CFG_CTRL_PRESENT, {15'($urandom), ($urandom_range(0, 7) != 0)});
    write_reg(CFG_CAL_ENABLE, {15'($urandom), ($urandom_range(0, 3) != 0)});
    write_reg(CFG_CAL_X_MIN, xl);
    write_reg(CFG_CAL_X_MAX, xh);
    write_reg(CFG_CAL_Y_MIN, yl);
    write_reg(CFG_CAL_Y_MAX, yh);
    if ($urandom_range(0, 1) != 0) write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1) != 0) write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // writes to unused indexes, then a touch while no controller is present
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0001);
    issue_poll(4'd1, 16'h0064, 16'h00C8, 1'b1);
    drain_results();

    // plain mirroring: screen edges, off-screen raw values, released polls holding the point
    write_reg(CFG_CTRL_PRESENT, 16'h0001);
    issue_poll(4'd1, 16'h0000, 16'hF000, 1'b1);
    issue_poll(4'd5, 16'hFFFF, 16'h01DF, 1'b1);
    issue_poll(4'd0, 16'h0010, 16'h0010, 1'b1);
    issue_poll(4'd6, 16'h0020, 16'h0020, 1'b1);
    issue_poll(4'd15, 16'h0030, 16'h0030, 1'b1);
    issue_poll(4'd3, 16'h01E0, 16'h00F0, 1'b1);
    issue_poll(4'd2, 16'h0A5A, 16'h05A5, 1'b0);
    issue_poll(4'd4, 16'h00F0, 16'h000D, 1'b1);
    drain_results();

    // calibration with the reset points
    write_reg(CFG_CAL_ENABLE, 16'h0001);
    issue_poll(4'd1, 16'h0000, 16'h01DF, 1'b1);
    issue_poll(4'd2, 16'h0FFF, 16'h0064, 1'b1);
    issue_poll(4'd5, 16'h0123, 16'h00FF, 1'b1);
    drain_results();

    // zero span on x, widest span on y
    write_reg(CFG_CAL_X_MIN, 16'd100);
    write_reg(CFG_CAL_X_MAX, 16'd100);
    write_reg(CFG_CAL_Y_MIN, 16'h8000);
    write_reg(CFG_CAL_Y_MAX, 16'h7FFF);
    issue_poll(4'd1, 16'h0000, 16'h0000, 1'b1);
    issue_poll(4'd1, 16'h0FFF, 16'h0FFF, 1'b1);
    issue_poll(4'd3, 16'h00FA, 16'h00FA, 1'b1);
    drain_results();

    // negative spans: reversed extremes on x, flipped screen on y
    write_reg(CFG_CAL_X_MIN, 16'h7FFF);
    write_reg(CFG_CAL_X_MAX, 16'h8000);
    write_reg(CFG_CAL_Y_MIN, 16'd479);
    write_reg(CFG_CAL_Y_MAX, 16'd0);
    issue_poll(4'd1, 16'h0000, 16'h0000, 1'b1);
    issue_poll(4'd2, 16'h01DF, 16'h0100, 1'b1);
    issue_poll(4'd5, 16'h0FFF, 16'h00C8, 1'b1);
    issue_poll(4'd1, 16'h0050, 16'h0050, 1'b0);
    drain_results();

    // random phases, each under its own setting; the last one runs without idling
    for (int p = 0; p < 6; p++) begin
      if (p == 5) quiet = 1'b1;
      configure_phase(p % 5);
      repeat (90) issue_random_poll();
      drain_results();
    end

    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("touch_point_calibrator_unit_test OK");
    else
      $display("touch_point_calibrator_unit_test NOT OK");
    $finish;
  end

endmodule
